// ===== hdl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants and types for the RPN stack calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int BCD_DIGITS  = 10;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int STEP_W      = $clog2(DATA_W);

  localparam logic [7:0] CHAR_OP_LO = 8'h2A;
  localparam logic [7:0] CHAR_OP_HI = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_TIMES = 8'h2A;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

  typedef struct packed {
    logic start;
    logic is_div;
  } rpn_alu_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// RPN bit-serial arithmetic unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rpn_alu (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rpn_pkg::rpn_alu_ctl_t      ctl_i,
  input  wire logic [rpn_pkg::DATA_W-1:0] a_i,
  input  wire logic [rpn_pkg::DATA_W-1:0] b_i,
  output logic                            done_o,
  output logic [rpn_pkg::DATA_W-1:0]      res_o
);
  import rpn_pkg::*;

  logic              busy_q, div_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] a_q, b_q, acc_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, a_q[DATA_W-1]};
  assign fits   = rem_sh >= {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= busy_q && !ctl_i.start && (step_q == STEP_W'(DATA_W - 1));
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      div_q <= ctl_i.is_div;
      neg_q <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      acc_q <= '0;
      rem_q <= '0;
      if (ctl_i.is_div) begin
        a_q <= a_i[DATA_W-1] ? DATA_W'(0) - a_i : a_i;
        b_q <= b_i[DATA_W-1] ? DATA_W'(0) - b_i : b_i;
      end else begin
        a_q <= a_i;
        b_q <= b_i;
      end
    end else if (busy_q) begin
      if (div_q) begin
        // Dividend bits move into the remainder; quotient bits fill a_q.
        rem_q <= fits ? DATA_W'(rem_sh - {1'b0, b_q}) : rem_sh[DATA_W-1:0];
        a_q   <= {a_q[DATA_W-2:0], fits};
      end else begin
        if (b_q[0]) acc_q <= acc_q + a_q;
        a_q <= {a_q[DATA_W-2:0], 1'b0};
        b_q <= {1'b0, b_q[DATA_W-1:1]};
      end
    end
  end

  always_comb begin
    if (div_q) res_o = neg_q ? DATA_W'(0) - a_q : a_q;
    else       res_o = acc_q;
  end
endmodule
`default_nettype wire

// ===== hdl/rpn_b2d.sv =====
// ----------------------------------------------------------------------------
// RPN binary to decimal converter
// Shift-and-add-3 conversion, one binary bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rpn_b2d (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rpn_pkg::DATA_W-1:0] mag_i,
  output logic                            done_o,
  output logic [rpn_pkg::BCD_W-1:0]       bcd_o
);
  import rpn_pkg::*;

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] bin_q;
  logic [BCD_W-1:0]  adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_o[4*i +: 4] >= 4'd5) ? bcd_o[4*i +: 4] + 4'd3 : bcd_o[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= busy_q && !start_i && (step_q == STEP_W'(DATA_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= mag_i;
      bcd_o <= '0;
    end else if (busy_q) begin
      bcd_o <= {adj[BCD_W-2:0], bin_q[DATA_W-1]};
      bin_q <= {bin_q[DATA_W-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rpn_stack_calculator_core.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Tokenizes ASCII bytes, runs a five-entry operand stack and prints results.
// ----------------------------------------------------------------------------
// Token bytes are absorbed while in_ready_o is high and produce no output item.
// Number terminators and error cases give one item in the cycle after acceptance.
// An operator's first character follows the S_ALU (multiply and divide only),
// S_APPLY, S_CONV and S_SKIP states, where leading zeros are skipped;
// characters then leave one per cycle while out_ready_i holds.
// Reset (rst_ni low, asynchronous) empties the stack and clears token state.
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_calculator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  output logic [1:0]       status_o,
  output logic [2:0]       depth_o,
  output logic signed [31:0] top_value_o
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALU   = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_CONV  = 3'd3;
  localparam logic [2:0] S_SKIP  = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;
  localparam logic [2:0] S_DIG   = 3'd6;
  localparam logic [2:0] S_TERM  = 3'd7;

  logic [2:0]        state_q;
  logic [DATA_W-1:0] stk_q [STACK_DEPTH];
  logic [CNT_W-1:0]  count_q;
  logic [DATA_W-1:0] acc_q, res_q, acc_d;
  logic [7:0]        first_q;
  logic              active_q, running_q, neg_q;
  logic [3:0]        left_q;
  logic [BCD_W-1:0]  dig_q;

  logic [7:0] tx_q;
  logic       last_q, valid_q, valid_d;
  logic [1:0] status_q;

  logic         accept, out_free, is_dig, is_op, first_dig;
  rpn_alu_ctl_t alu_ctl;
  logic         alu_done, b2d_start, b2d_done;
  logic [DATA_W-1:0] alu_res;
  logic [BCD_W-1:0]  bcd;

  assign out_free   = !valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_dig     = rx_byte_i >= CHAR_ZERO && rx_byte_i <= CHAR_NINE;
  assign is_op      = rx_byte_i >= CHAR_OP_LO && rx_byte_i <= CHAR_OP_HI;
  assign first_dig  = first_q >= CHAR_ZERO && first_q <= CHAR_NINE;
  assign acc_d      = {acc_q[DATA_W-4:0], 3'b000} + {acc_q[DATA_W-2:0], 1'b0}
                      + DATA_W'(rx_byte_i - CHAR_ZERO);

  assign alu_ctl.start  = accept && !is_dig && !is_op && active_q && !first_dig
                          && count_q >= CNT_W'(2)
                          && (first_q == CHAR_TIMES
                              || (first_q == CHAR_DIV && stk_q[1] != '0));
  assign alu_ctl.is_div = first_q == CHAR_DIV;
  assign b2d_start      = state_q == S_APPLY;

  rpn_alu u_alu (
    .clk_i (clk_i), .rst_ni(rst_ni), .ctl_i(alu_ctl),
    .a_i   (stk_q[0]), .b_i(stk_q[1]), .done_o(alu_done), .res_o(alu_res)
  );

  rpn_b2d u_b2d (
    .clk_i  (clk_i), .rst_ni(rst_ni), .start_i(b2d_start),
    .mag_i  (res_q[DATA_W-1] ? DATA_W'(0) - res_q : res_q),
    .done_o (b2d_done), .bcd_o(bcd)
  );

  // An item is loaded whenever a character is emitted or a single-item
  // terminator is accepted; otherwise a taken item empties the register.
  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if ((state_q == S_SIGN || state_q == S_DIG || state_q == S_TERM) && out_free) begin
      valid_d = 1'b1;
    end
    if (accept && !is_dig && !is_op && active_q
        && (first_dig || count_q < CNT_W'(2)
            || (first_q == CHAR_DIV && stk_q[1] == '0))) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      acc_q     <= '0;
      first_q   <= '0;
      active_q  <= 1'b0;
      running_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_dig || is_op) begin
              if (!active_q) begin
                active_q  <= 1'b1;
                first_q   <= rx_byte_i;
                acc_q     <= is_dig ? DATA_W'(rx_byte_i - CHAR_ZERO) : '0;
                running_q <= is_dig;
              end else if (running_q) begin
                if (is_dig) acc_q <= acc_d;
                else        running_q <= 1'b0;
              end
            end else if (active_q) begin
              active_q  <= 1'b0;
              running_q <= 1'b0;
              acc_q     <= '0;
              if (first_dig) begin
                if (count_q != CNT_W'(STACK_DEPTH)) count_q <= count_q + 1'b1;
              end else if (count_q >= CNT_W'(2)) begin
                if (first_q == CHAR_TIMES || first_q == CHAR_DIV) begin
                  if (alu_ctl.start) state_q <= S_ALU;
                end else begin
                  state_q <= S_APPLY;
                end
              end
            end
          end
        end
        S_ALU:   if (alu_done) state_q <= S_APPLY;
        S_APPLY: begin
          count_q <= count_q - 1'b1;
          state_q <= S_CONV;
        end
        S_CONV:  if (b2d_done) state_q <= S_SKIP;
        S_SKIP: begin
          if (dig_q[BCD_W-1 -: 4] != 4'd0 || left_q == 4'd1) begin
            state_q <= neg_q ? S_SIGN : S_DIG;
          end
        end
        S_SIGN:  if (out_free) state_q <= S_DIG;
        S_DIG:   if (out_free && left_q == 4'd1) state_q <= S_TERM;
        S_TERM:  if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && !is_dig && !is_op && active_q) begin
          tx_q   <= CHAR_NUL;
          last_q <= 1'b1;
          if (first_dig) begin
            if (count_q != CNT_W'(STACK_DEPTH)) begin
              stk_q[0] <= acc_q;
              for (int i = 1; i < STACK_DEPTH; i++) stk_q[i] <= stk_q[i-1];
              status_q <= ST_OK;
            end else begin
              status_q <= ST_FULL;
            end
          end else if (count_q < CNT_W'(2)) begin
            status_q <= ST_UNDERFLOW;
          end else if (first_q == CHAR_DIV && stk_q[1] == '0) begin
            status_q <= ST_DIV_ZERO;
          end else begin
            status_q <= ST_OK;
          end
          if (first_q == CHAR_PLUS)       res_q <= stk_q[0] + stk_q[1];
          else if (first_q == CHAR_MINUS) res_q <= stk_q[0] - stk_q[1];
          else                            res_q <= '0;
        end
      end
      S_ALU: if (alu_done) res_q <= alu_res;
      S_APPLY: begin
        stk_q[0] <= res_q;
        for (int i = 1; i < STACK_DEPTH - 1; i++) stk_q[i] <= stk_q[i+1];
        neg_q  <= res_q[DATA_W-1];
        left_q <= 4'(BCD_DIGITS);
      end
      S_CONV: if (b2d_done) dig_q <= bcd;
      S_SKIP: begin
        if (dig_q[BCD_W-1 -: 4] == 4'd0 && left_q != 4'd1) begin
          dig_q  <= {dig_q[BCD_W-5:0], 4'd0};
          left_q <= left_q - 1'b1;
        end
      end
      S_SIGN: if (out_free) begin
        tx_q   <= CHAR_MINUS;
        last_q <= 1'b0;
      end
      S_DIG: if (out_free) begin
        tx_q   <= CHAR_ZERO + 8'(dig_q[BCD_W-1 -: 4]);
        last_q <= 1'b0;
        dig_q  <= {dig_q[BCD_W-5:0], 4'd0};
        left_q <= left_q - 1'b1;
      end
      S_TERM: if (out_free) begin
        tx_q   <= CHAR_NUL;
        last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = valid_q;
  assign tx_byte_o   = tx_q;
  assign last_o      = last_q;
  assign status_o    = status_q;
  assign depth_o     = 3'(count_q);
  assign top_value_o = (count_q == '0) ? '0 : signed'(stk_q[0]);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_apply_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |-> count_q >= CNT_W'(2)) else $error("pop without operands");
  a_out_empty_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALU || state_q == S_CONV) |-> !valid_q)
    else $error("output held during compute");
  a_alu_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_ctl.start |=> state_q == S_ALU) else $error("alu start lost");
endmodule
`default_nettype wire
